### design/point_projection_zbuffer_macros.svh
// Assertion macros used by the checker file.
`ifndef POINT_PROJECTION_ZBUFFER_MACROS_SVH
`define POINT_PROJECTION_ZBUFFER_MACROS_SVH

// Same-cycle implication.
`define PPZ_ASSERT_SAME(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PPZ_ASSERT_NEXT(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

### design/ppz_pkg.sv
// Shared types and constants for the projection z-buffer.
package ppz_pkg;

  localparam int VIEW_WIDTH_DEF  = 240;
  localparam int VIEW_HEIGHT_DEF = 244;
  localparam int MIN_CELL_DEF    = 2;

  localparam int FOCAL_LEN  = 200;
  localparam int NEAR_DEPTH = 80;
  localparam int ROT_SHIFT  = 28;
  localparam int ROT_W      = 24;
  localparam int DIV_NUM_W  = 32;
  localparam int DIV_DEN_W  = 23;

  localparam logic signed [15:0] QUAT_R_RST = 16'sd16384;
  localparam logic [3:0]         CELL_RST   = 4'd3;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_STORED = 2'd1,
    CMD_LIVE   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_QUAT_R = 3'd0,
    REG_QUAT_I = 3'd1,
    REG_QUAT_J = 3'd2,
    REG_QUAT_K = 3'd3,
    REG_CELL   = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROT,
    ST_PDIV,
    ST_BDIV,
    ST_ADDR,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [15:0] r;
    logic signed [15:0] i;
    logic signed [15:0] j;
    logic signed [15:0] k;
  } quat_t;

endpackage

### design/point_projection_zbuffer.sv
// Top level: projection of world points into a nearest-distance cell grid.
//
//  channel  | dir | payload
//  s_*      | in  | tuser: cmd; tdata: pos_x, pos_y, pos_z, distance, read_col, read_row
//  m_*      | out | tdata: hit, cell_x, cell_y, near_dist, live_flag
//  cfg_*    | in  | register writes, no read-back
//
// One item at a time. From one transfer in to the next, a point passes through the
// rotation pipeline, the projection and then the binning pass of the shared bit-serial
// dividers, a read and a write of the grid memory, the load of the result and the
// return to idle. After reset and after a clear command the grid memory is swept one
// cell a cycle, with s_tready low. A held result does not stop the next transfer in;
// the finished result waits until the output register is free.
module point_projection_zbuffer #(
  parameter int VIEW_WIDTH  = ppz_pkg::VIEW_WIDTH_DEF,
  parameter int VIEW_HEIGHT = ppz_pkg::VIEW_HEIGHT_DEF,
  parameter int MIN_CELL    = ppz_pkg::MIN_CELL_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // pos_x, pos_y, pos_z, distance, read_col, read_row, pad
  input  logic [1:0]  s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // hit, cell_x, cell_y, near_dist, live_flag, pad
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ppz_pkg::*;

  localparam int GRID_W   = VIEW_WIDTH / MIN_CELL;
  localparam int GRID_H   = VIEW_HEIGHT / MIN_CELL;
  localparam int DEPTH    = GRID_W * GRID_H;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int GRID_MAX = (GRID_W > GRID_H) ? GRID_W : GRID_H;
  localparam int IX_W     = $clog2((GRID_MAX > 128) ? GRID_MAX : 128);
  localparam int AMUL_W   = IX_W + ADDR_W;
  localparam int SX_W     = DIV_NUM_W + 2;

  state_t state, state_next;

  quat_t      quat;
  logic [3:0] cell_size;
  logic [3:0] cs_eff;

  cmd_t                     in_cmd;
  logic [14:0]              in_dist;
  logic [6:0]               in_col, in_row;
  logic                     accept;

  cmd_t                     cmd_r;
  logic [14:0]              dist_r;
  logic [IX_W-1:0]          gx, gy;
  logic                     neg_x, neg_y;
  logic [ADDR_W-1:0]        clr_addr;
  logic                     clr_reply;
  logic                     res_hit, res_lf;
  logic [6:0]               res_cx, res_cy;
  logic [14:0]              res_nd;

  logic                     rot_start, rot_valid;
  logic signed [ROT_W-1:0]  rx, ry, rz;
  logic                     near_ok;
  logic signed [DIV_NUM_W-1:0] fx, fy;
  logic [DIV_NUM_W-1:0]     mag_x, mag_y;

  logic                     div_start, done_x, done_y;
  logic [DIV_NUM_W-1:0]     num_x, num_y, quo_x, quo_y;
  logic [DIV_DEN_W-1:0]     div_den;
  logic signed [SX_W-1:0]   qx, qy, sx, sy;
  logic                     in_view;

  logic [ADDR_W-1:0]        cell_addr, mem_addr;
  logic                     mem_we;
  logic [15:0]              mem_wdata, mem_rdata, cell_new, cell_v;
  logic [15:0]              grid_mem [DEPTH];
  logic                     out_load;

  assign in_cmd  = cmd_t'(s_tuser);
  assign in_dist = s_tdata[62:48];
  assign in_col  = s_tdata[69:63];
  assign in_row  = s_tdata[76:70];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign cs_eff   = (cell_size < 4'(MIN_CELL)) ? 4'(MIN_CELL) : cell_size;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      quat.r    <= QUAT_R_RST;
      quat.i    <= '0;
      quat.j    <= '0;
      quat.k    <= '0;
      cell_size <= CELL_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_QUAT_R: quat.r    <= cfg_data;
        REG_QUAT_I: quat.i    <= cfg_data;
        REG_QUAT_J: quat.j    <= cfg_data;
        REG_QUAT_K: quat.k    <= cfg_data;
        REG_CELL:   cell_size <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign rot_start = accept && (in_cmd == CMD_STORED || in_cmd == CMD_LIVE) && in_dist != '0;

  ppz_rot u_rot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rot_start),
    .quat      (quat),
    .vx        (s_tdata[15:0]),
    .vy        (s_tdata[31:16]),
    .vz        (s_tdata[47:32]),
    .out_valid (rot_valid),
    .rx        (rx),
    .ry        (ry),
    .rz        (rz)
  );

  assign near_ok = rz >= ROT_W'(NEAR_DEPTH);
  assign fx      = DIV_NUM_W'(rx) * DIV_NUM_W'(FOCAL_LEN);
  assign fy      = DIV_NUM_W'(ry) * DIV_NUM_W'(FOCAL_LEN);
  assign mag_x   = fx[DIV_NUM_W-1] ? DIV_NUM_W'(-fx) : DIV_NUM_W'(fx);
  assign mag_y   = fy[DIV_NUM_W-1] ? DIV_NUM_W'(-fy) : DIV_NUM_W'(fy);

  // screen position from the projection quotients
  assign qx = neg_x ? -SX_W'(quo_x) : SX_W'(quo_x);
  assign qy = neg_y ? -SX_W'(quo_y) : SX_W'(quo_y);
  assign sx = SX_W'(VIEW_WIDTH / 2) + qx;
  assign sy = SX_W'(VIEW_HEIGHT / 2) + qy;
  assign in_view = !sx[SX_W-1] && !sy[SX_W-1] &&
                   sx < SX_W'(VIEW_WIDTH) && sy < SX_W'(VIEW_HEIGHT);

  // the dividers do the projection first, then the binning
  assign div_start = (state == ST_ROT && rot_valid && near_ok) ||
                     (state == ST_PDIV && done_x && in_view);
  assign num_x   = (state == ST_ROT) ? mag_x : DIV_NUM_W'($unsigned(sx));
  assign num_y   = (state == ST_ROT) ? mag_y : DIV_NUM_W'($unsigned(sy));
  assign div_den = (state == ST_ROT) ? rz[DIV_DEN_W-1:0] : DIV_DEN_W'(cs_eff);

  ppz_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_x),
    .den   (div_den),
    .done  (done_x),
    .quo   (quo_x)
  );

  ppz_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_y),
    .den   (div_den),
    .done  (done_y),
    .quo   (quo_y)
  );

  // grid memory: column-major, one port
  assign cell_addr = ADDR_W'(AMUL_W'(gx) * AMUL_W'(GRID_H) + AMUL_W'(gy));
  assign mem_addr  = (state == ST_CLEAR) ? clr_addr : cell_addr;
  assign mem_we    = (state == ST_CLEAR) || (state == ST_READ && cmd_r != CMD_READ);
  assign mem_wdata = (state == ST_CLEAR) ? 16'd0 : cell_new;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_addr] <= mem_wdata;
    end
    mem_rdata <= grid_mem[mem_addr];
  end

  always_comb begin
    cell_new = mem_rdata;
    if (mem_rdata[14:0] == '0 || dist_r < mem_rdata[14:0]) begin
      cell_new = {mem_rdata[15], dist_r};
    end
    if (cmd_r == CMD_LIVE) begin
      cell_new[15] = 1'b1;
    end
  end

  assign cell_v   = (cmd_r == CMD_READ) ? mem_rdata : cell_new;
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_cmd;
      dist_r  <= in_dist;
      res_hit <= 1'b0;
      res_nd  <= '0;
      res_lf  <= 1'b0;
      res_cx  <= (in_cmd == CMD_READ) ? in_col : 7'd0;
      res_cy  <= (in_cmd == CMD_READ) ? in_row : 7'd0;
      gx      <= IX_W'(in_col);
      gy      <= IX_W'(in_row);
    end
    if (state == ST_ROT) begin
      neg_x <= fx[DIV_NUM_W-1];
      neg_y <= fy[DIV_NUM_W-1];
    end
    if (state == ST_BDIV && done_x) begin
      gx <= (quo_x >= DIV_NUM_W'(GRID_W)) ? IX_W'(GRID_W - 1) : quo_x[IX_W-1:0];
      gy <= (quo_y >= DIV_NUM_W'(GRID_H)) ? IX_W'(GRID_H - 1) : quo_y[IX_W-1:0];
    end
    if (state == ST_READ) begin
      res_hit <= 1'b1;
      res_cx  <= gx[6:0];
      res_cy  <= gy[6:0];
      res_nd  <= cell_v[14:0];
      res_lf  <= cell_v[15];
    end
    if (out_load) begin
      m_tdata <= {1'b0, res_lf, res_nd, res_cy, res_cx, res_hit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && in_cmd == CMD_CLEAR) begin
        clr_addr  <= '0;
        clr_reply <= 1'b1;
      end else if (state == ST_CLEAR) begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          clr_addr  <= '0;
          clr_reply <= 1'b0;
        end else begin
          clr_addr <= clr_addr + ADDR_W'(1);
        end
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = clr_reply ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_CLEAR: state_next = ST_CLEAR;
            CMD_READ: begin
              state_next = (7'(in_col) < 7'(GRID_W > 127 ? 127 : GRID_W) ||
                            GRID_W > 127) &&
                           (7'(in_row) < 7'(GRID_H > 127 ? 127 : GRID_H) ||
                            GRID_H > 127) ? ST_ADDR : ST_DONE;
            end
            CMD_STORED, CMD_LIVE: state_next = (in_dist != '0) ? ST_ROT : ST_DONE;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_ROT: begin
        if (rot_valid) begin
          state_next = near_ok ? ST_PDIV : ST_DONE;
        end
      end
      ST_PDIV: begin
        if (done_x) begin
          state_next = in_view ? ST_BDIV : ST_DONE;
        end
      end
      ST_BDIV: begin
        if (done_y) begin
          state_next = ST_ADDR;
        end
      end
      ST_ADDR: state_next = ST_READ;
      ST_READ: state_next = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### design/ppz_rot.sv
// Four-stage rotation of a point by the conjugate quaternion, truncated to whole mm.
module ppz_rot (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  ppz_pkg::quat_t                     quat,
  input  logic signed [15:0]                 vx,
  input  logic signed [15:0]                 vy,
  input  logic signed [15:0]                 vz,
  output logic                               out_valid,
  output logic signed [ppz_pkg::ROT_W-1:0]   rx,
  output logic signed [ppz_pkg::ROT_W-1:0]   ry,
  output logic signed [ppz_pkg::ROT_W-1:0]   rz
);
  import ppz_pkg::*;

  localparam int TW = 35;
  localparam int PW = 56;
  localparam logic signed [PW-1:0] RBIAS = (PW'(1) <<< ROT_SHIFT) - PW'(1);

  logic signed [16:0]   a, b, c, d;
  logic signed [16:0]   a1, b1, c1, d1;
  logic signed [15:0]   vx1, vy1, vz1, vx2, vy2, vz2;
  logic signed [TW-1:0] tx1, ty1, tz1;
  logic signed [PW-1:0] p_atx, p_ctz, p_dty, p_aty, p_dtx, p_btz, p_atz, p_bty, p_ctx;
  logic signed [PW-1:0] sx3, sy3, sz3;
  logic signed [PW-1:0] bx, by, bz;
  logic [3:0]           vld;

  assign a = 17'(quat.r);
  assign b = -17'(quat.i);
  assign c = -17'(quat.j);
  assign d = -17'(quat.k);

  // t = 2 (u x v)
  always_ff @(posedge clk) begin
    a1  <= a;
    b1  <= b;
    c1  <= c;
    d1  <= d;
    vx1 <= vx;
    vy1 <= vy;
    vz1 <= vz;
    tx1 <= (TW'(c) * TW'(vz) - TW'(d) * TW'(vy)) <<< 1;
    ty1 <= (TW'(d) * TW'(vx) - TW'(b) * TW'(vz)) <<< 1;
    tz1 <= (TW'(b) * TW'(vy) - TW'(c) * TW'(vx)) <<< 1;
  end

  always_ff @(posedge clk) begin
    vx2   <= vx1;
    vy2   <= vy1;
    vz2   <= vz1;
    p_atx <= PW'(a1) * PW'(tx1);
    p_ctz <= PW'(c1) * PW'(tz1);
    p_dty <= PW'(d1) * PW'(ty1);
    p_aty <= PW'(a1) * PW'(ty1);
    p_dtx <= PW'(d1) * PW'(tx1);
    p_btz <= PW'(b1) * PW'(tz1);
    p_atz <= PW'(a1) * PW'(tz1);
    p_bty <= PW'(b1) * PW'(ty1);
    p_ctx <= PW'(c1) * PW'(tx1);
  end

  always_ff @(posedge clk) begin
    sx3 <= (PW'(vx2) <<< ROT_SHIFT) + p_atx + p_ctz - p_dty;
    sy3 <= (PW'(vy2) <<< ROT_SHIFT) + p_aty + p_dtx - p_btz;
    sz3 <= (PW'(vz2) <<< ROT_SHIFT) + p_atz + p_bty - p_ctx;
  end

  // truncate toward zero
  assign bx = (sx3 + (sx3[PW-1] ? RBIAS : '0)) >>> ROT_SHIFT;
  assign by = (sy3 + (sy3[PW-1] ? RBIAS : '0)) >>> ROT_SHIFT;
  assign bz = (sz3 + (sz3[PW-1] ? RBIAS : '0)) >>> ROT_SHIFT;

  always_ff @(posedge clk) begin
    rx <= bx[ROT_W-1:0];
    ry <= by[ROT_W-1:0];
    rz <= bz[ROT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], in_valid};
    end
  end

  assign out_valid = vld[3];

endmodule

### design/ppz_div.sv
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
module ppz_div #(
  parameter int NUM_W = ppz_pkg::DIV_NUM_W,
  parameter int DEN_W = ppz_pkg::DIV_DEN_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] sh;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dv;
  logic [DEN_W:0]   trial;
  logic             ge;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  assign trial = {rem, sh[NUM_W-1]};
  assign ge    = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= num;
      rem <= '0;
      dv  <= den;
    end else if (busy) begin
      sh  <= {sh[NUM_W-2:0], ge};
      rem <= ge ? DEN_W'(trial - {1'b0, dv}) : trial[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt  <= cnt - CNT_W'(1);
      done <= (cnt == CNT_W'(1));
      busy <= (cnt != CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  assign quo = sh;

endmodule

### design/ppz_chk.sv
// Port-level checker for the projection z-buffer, bound to the top level.
`include "point_projection_zbuffer_macros.svh"

module ppz_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // a held result does not change
  `PPZ_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // one item at a time
  `PPZ_ASSERT_NEXT(a_one_item, clk, rst, s_tvalid && s_tready, !s_tready, "second transfer taken while busy")

  // a miss carries no cell contents
  `PPZ_ASSERT_SAME(a_miss_empty, clk, rst, m_tvalid && !m_tdata[0], m_tdata[31:15] == 17'd0, "miss with cell contents")

endmodule

bind point_projection_zbuffer ppz_chk u_ppz_chk (.*);

### tb/tb_point_projection_zbuffer.sv
// Self-checking testbench for the projection z-buffer: directed and random streams.
module tb_point_projection_zbuffer;
  import ppz_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_W = VIEW_WIDTH_DEF / MIN_CELL_DEF;
  localparam int GRID_H = VIEW_HEIGHT_DEF / MIN_CELL_DEF;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic        live_flag;
    logic [14:0] near_dist;
    logic [6:0]  cell_y;
    logic [6:0]  cell_x;
    logic        hit;
  } cell_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;   // pos_x, pos_y, pos_z, distance, read_col, read_row, pad
  logic [1:0]  s_tuser = '0;   // cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // hit, cell_x, cell_y, near_dist, live_flag, pad
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  point_projection_zbuffer dut (.*);

  always #6 clk = ~clk;

  // predictor state
  logic signed [15:0] q_r = QUAT_R_RST, q_i = '0, q_j = '0, q_k = '0;
  logic [3:0]         cell_cfg = CELL_RST;
  logic [15:0]        grid_mirror [GRID_W*GRID_H];
  cell_res_t          pending_cells [$];

  int  errors = 0;
  int  cycles = 0;
  int  n_items = 0, n_hits = 0, n_reads = 0, n_clears = 0;
  bit  quiet = 1'b0;
  int  hold_gen = 0, hold_seen = 0, hold_left = 0;
  logic [6:0] last_cx = '0, last_cy = '0;

  task automatic report(string what, int got, int want);
    $display("MISMATCH %s: got %0d want %0d (item %0d)", what, got, want, n_items);
    errors++;
  endtask

  function automatic cell_res_t project_point(cmd_t cmd, logic signed [15:0] px,
      logic signed [15:0] py, logic signed [15:0] pz, logic [14:0] pt_dist,
      logic [6:0] col, logic [6:0] row);
    cell_res_t r;
    longint a, b, c, d, vx, vy, vz, tx, ty, tz, rx, ry, rz, sx, sy, one;
    int cs, gx, gy;
    logic [15:0] cv;
    r = '0;
    if (cmd == CMD_CLEAR) begin
      foreach (grid_mirror[n]) grid_mirror[n] = '0;
      return r;
    end
    if (cmd == CMD_READ) begin
      r.cell_x = col;
      r.cell_y = row;
      if (col >= GRID_W || row >= GRID_H) return r;
      cv = grid_mirror[col*GRID_H + row];
      r.hit = 1'b1;
      r.near_dist = cv[14:0];
      r.live_flag = cv[15];
      return r;
    end
    if (pt_dist == 0) return r;
    a = q_r; b = -longint'(q_i); c = -longint'(q_j); d = -longint'(q_k);
    vx = px; vy = py; vz = pz;
    one = longint'(1) <<< 28;
    tx = 2 * (c*vz - d*vy);
    ty = 2 * (d*vx - b*vz);
    tz = 2 * (b*vy - c*vx);
    rx = (vx*one + a*tx + (c*tz - d*ty)) / one;
    ry = (vy*one + a*ty + (d*tx - b*tz)) / one;
    rz = (vz*one + a*tz + (b*ty - c*tx)) / one;
    if (rz < NEAR_DEPTH) return r;
    sx = VIEW_WIDTH_DEF/2 + (FOCAL_LEN*rx) / rz;
    sy = VIEW_HEIGHT_DEF/2 + (FOCAL_LEN*ry) / rz;
    if (sx < 0 || sx >= VIEW_WIDTH_DEF || sy < 0 || sy >= VIEW_HEIGHT_DEF) return r;
    cs = (cell_cfg < MIN_CELL_DEF) ? MIN_CELL_DEF : cell_cfg;
    gx = int'(sx) / cs;
    gy = int'(sy) / cs;
    if (gx >= GRID_W) gx = GRID_W - 1;
    if (gy >= GRID_H) gy = GRID_H - 1;
    cv = grid_mirror[gx*GRID_H + gy];
    if (cv[14:0] == 0 || pt_dist < cv[14:0]) cv[14:0] = pt_dist;
    if (cmd == CMD_LIVE) cv[15] = 1'b1;
    grid_mirror[gx*GRID_H + gy] = cv;
    r.hit = 1'b1;
    r.cell_x = gx[6:0];
    r.cell_y = gy[6:0];
    r.near_dist = cv[14:0];
    r.live_flag = cv[15];
    return r;
  endfunction

  task automatic send_item(cmd_t cmd, logic signed [15:0] px, logic signed [15:0] py,
      logic signed [15:0] pz, logic [14:0] pt_dist, logic [6:0] col, logic [6:0] row);
    cell_res_t r;
    if (!quiet && $urandom_range(99) < 21) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 21);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {3'b0, row, col, pt_dist, pz, py, px};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = project_point(cmd, px, py, pz, pt_dist, col, row);
    pending_cells.push_back(r);
    n_items++;
    if (cmd == CMD_CLEAR) n_clears++;
    if (cmd == CMD_READ) n_reads++;
    if (r.hit && cmd != CMD_READ) begin
      last_cx = r.cell_x;
      last_cy = r.cell_y;
    end
  endtask

  // sender pauses until every expected result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_QUAT_R: q_r = val;
      REG_QUAT_I: q_i = val;
      REG_QUAT_J: q_j = val;
      REG_QUAT_K: q_k = val;
      REG_CELL:   cell_cfg = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_view(logic [15:0] r, logic [15:0] i, logic [15:0] j,
      logic [15:0] k, logic [15:0] cs);
    drain();
    write_reg(REG_QUAT_R, r);
    write_reg(REG_QUAT_I, i);
    write_reg(REG_QUAT_J, j);
    write_reg(REG_QUAT_K, k);
    write_reg(REG_CELL, cs);
  endtask

  task automatic send_random();
    int sel, lim, zz;
    cmd_t cmd;
    logic signed [15:0] px, py, pz;
    logic [14:0] pt_dist;
    logic [6:0] col, row;
    sel = $urandom_range(99);
    cmd = sel < 1 ? CMD_CLEAR : sel < 21 ? CMD_READ : sel < 60 ? CMD_STORED : CMD_LIVE;
    if ($urandom_range(99) < 10) begin
      // noise: whole field ranges
      px = 16'($urandom); py = 16'($urandom); pz = 16'($urandom);
      pt_dist = 15'($urandom); col = 7'($urandom); row = 7'($urandom);
    end else begin
      zz = $urandom_range(80, 4000);
      lim = ($urandom_range(99) < 30) ? 15 : zz/2;
      pz = 16'(zz);
      px = 16'(int'($urandom_range(2*lim)) - lim);
      py = 16'(int'($urandom_range(2*lim)) - lim);
      sel = $urandom_range(99);
      pt_dist = sel < 3 ? 15'd0 : sel < 40 ? 15'($urandom_range(1, 60))
                                          : 15'($urandom_range(1, 32767));
      if ($urandom_range(1)) begin
        col = last_cx; row = last_cy;
      end else begin
        col = 7'($urandom_range(GRID_W-1)); row = 7'($urandom_range(GRID_H-1));
      end
    end
    send_item(cmd, px, py, pz, pt_dist, col, row);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_gen != hold_seen) begin
      hold_seen <= hold_gen;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= quiet || $urandom_range(99) >= 21;
    end
  end

  always @(posedge clk) begin
    cell_res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[30:0];
      if (pending_cells.size() == 0) begin
        report("unexpected result", got, 0);
      end else begin
        want = pending_cells.pop_front();
        if (got.hit != want.hit) report("hit", got.hit, want.hit);
        if (got.cell_x != want.cell_x) report("cell_x", got.cell_x, want.cell_x);
        if (got.cell_y != want.cell_y) report("cell_y", got.cell_y, want.cell_y);
        if (got.near_dist != want.near_dist)
          report("near_dist", got.near_dist, want.near_dist);
        if (got.live_flag != want.live_flag)
          report("live_flag", got.live_flag, want.live_flag);
        if (want.hit) n_hits++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_cells.size());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(CMD_READ, 0, 0, 0, 0, 0, 0);
    send_item(CMD_STORED, 0, 0, 1000, 500, 0, 0);          // centre cell
    send_item(CMD_LIVE, 0, 0, 1000, 900, 0, 0);            // live flag without winning
    send_item(CMD_STORED, 0, 0, 1000, 100, 0, 0);          // nearer wins
    send_item(CMD_READ, 0, 0, 0, 0, 40, 40);
    send_item(CMD_STORED, 0, 0, 1000, 0, 0, 0);            // no distance
    send_item(CMD_LIVE, 0, 0, 1000, 0, 0, 0);
    send_item(CMD_STORED, 0, 0, 79, 32767, 0, 0);          // too near
    send_item(CMD_STORED, 0, 0, 80, 32767, 0, 0);
    send_item(CMD_STORED, 32767, 0, 80, 5, 0, 0);          // off view
    send_item(CMD_LIVE, -32767, -32767, -32767, 5, 0, 0);
    send_item(CMD_LIVE, -47, -48, 80, 7, 0, 0);            // top-left corner
    send_item(CMD_LIVE, 47, 48, 80, 7, 0, 0);              // bottom-right
    send_item(CMD_READ, 0, 0, 0, 0, 119, 121);
    send_item(CMD_READ, 0, 0, 0, 0, 120, 0);               // outside the grid
    send_item(CMD_READ, 0, 0, 0, 0, 0, 122);
    send_item(CMD_READ, 0, 0, 0, 0, 127, 127);
    set_view(16'd16384, 16'd0, 16'd0, 16'd0, 16'd0);       // below minimum cell
    send_item(CMD_STORED, 47, 48, 80, 9, 0, 0);
    set_view(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd8); // unnormalised
    send_item(CMD_STORED, 100, 200, 3000, 10, 0, 0);
    set_view(16'd16384, 16'd0, 16'd0, 16'd0, 16'd15);
    send_item(CMD_STORED, 40, -40, 90, 11, 0, 0);
    send_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
    send_item(CMD_READ, 0, 0, 0, 0, 40, 40);
  endtask

  task automatic test_random_views();
    logic [15:0] views [8][5];
    views = '{'{16384, 0, 0, 0, 2}, '{0, 0, 0, 16384, 8}, '{11585, 0, 0, 11585, 3},
              '{11585, 0, 0, 16'hD2BF, 5}, '{16'hC000, 0, 0, 0, 1},
              '{11585, 11585, 0, 0, 4}, '{16384, 0, 0, 0, 3}, '{0, 0, 0, 0, 6}};
    for (int p = 0; p < 9; p++) begin
      if (p < 8)
        set_view(views[p][0], views[p][1], views[p][2], views[p][3], views[p][4]);
      else
        set_view(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom_range(15)));
      quiet = (p == 2);
      repeat (96) send_random();
      quiet = 1'b0;
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_gen++;
    repeat (12) send_random();
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (grid_mirror[n]) grid_mirror[n] = '0;
    test_directed();
    test_random_views();
    test_backpressure();
    drain();
    repeat (100) @(posedge clk);
    if (pending_cells.size() != 0) report("results never arrived", pending_cells.size(), 0);
    $display("covered %0d items (%0d reads, %0d clears), %0d grid hits, 12 view settings",
             n_items, n_reads, n_clears, n_hits);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb: failure");
    end
    $finish;
  end
endmodule
